/* hdl/mpq_pkg.sv */
// ============================================================================
// Sorted max-priority queue package
// Shared types and codes for the cell row and the queue top level.
// ============================================================================
package mpq_pkg;

    // Operation carried by an input request.
    typedef enum logic {
        FN_INSERT = 1'b0,
        FN_REMOVE = 1'b1
    } t_func;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } t_status;

    localparam int STATUS_WIDTH = 2;

    // Command broadcast to every cell of the row in the same cycle.
    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_cmd;

endpackage

/* hdl/mpq_cell.sv */
// ============================================================================
// Sorted queue cell
// Holds one entry of the descending row; on insert it keeps its entry, takes
// the new value or takes its left neighbor's entry, and on remove it takes its
// right neighbor's entry.
// ============================================================================
module mpq_cell #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mpq_pkg::t_cell_cmd            i_cmd,
    input  logic signed [VALUE_WIDTH-1:0] i_new_value,
    input  logic signed [VALUE_WIDTH-1:0] i_prev_value,
    input  logic                          i_prev_valid,
    input  logic                          i_prev_ge,
    input  logic signed [VALUE_WIDTH-1:0] i_next_value,
    input  logic                          i_next_valid,
    output logic signed [VALUE_WIDTH-1:0] o_value,
    output logic                          o_valid,
    output logic                          o_ge
);

    logic signed [VALUE_WIDTH-1:0] r_value;
    logic signed [VALUE_WIDTH-1:0] n_value;
    logic                          r_valid;
    logic                          n_valid;

    // A stored entry greater than or equal to the new value stays ahead of it,
    // which keeps equal values in arrival order.
    assign o_ge    = r_valid && (r_value >= i_new_value);
    assign o_value = r_value;
    assign o_valid = r_valid;

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_cmd.ins) begin
            if (!o_ge) begin
                n_value = i_prev_ge ? i_new_value : i_prev_value;
                n_valid = r_valid || i_prev_valid;
            end
        end else if (i_cmd.rem) begin
            n_value = i_next_value;
            n_valid = i_next_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

/* hdl/max_priority_queue_sorted.sv */
// Output: a result is held in the output register from the cycle after its request is accepted.
// Throughput: one request per cycle while the receiver takes each result; every cell
// compares and shifts in the same cycle, so the row of CAPACITY cells sets the clock path, not the rate.
// Reset: count, cell valid bits and the output valid clear; entry values do not.
// A new request enters only while the output register is empty or its result
// is taken in the same cycle.
// ============================================================================
// Sorted max-priority queue
// Bounded queue of signed values kept in descending order in a row of cells;
// insert places a value behind all entries not less than it, remove pops the
// largest.
// ============================================================================
module max_priority_queue_sorted #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_func,
    input  logic signed [VALUE_WIDTH-1:0]        i_value,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [VALUE_WIDTH-1:0]        o_removed_value,
    output logic [mpq_pkg::STATUS_WIDTH-1:0]     o_status,
    output logic [$clog2(CAPACITY+1)-1:0]        o_count
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [VALUE_WIDTH-1:0] w_value [CAPACITY];
    logic                          w_valid [CAPACITY];
    logic                          w_ge    [CAPACITY];

    logic [CW-1:0]                 r_count;
    logic [CW-1:0]                 n_count;
    logic                          r_out_valid;
    logic signed [VALUE_WIDTH-1:0] r_removed;
    logic signed [VALUE_WIDTH-1:0] n_removed;
    mpq_pkg::t_status              r_status;
    mpq_pkg::t_status              n_status;

    logic                          accept;
    logic                          is_remove;
    logic                          full;
    logic                          empty;
    mpq_pkg::t_cell_cmd            cmd;

    assign o_ready   = !r_out_valid || i_ready;
    assign accept    = i_valid && o_ready;
    assign is_remove = (i_func == mpq_pkg::FN_REMOVE);
    assign full      = (r_count == CW'(CAPACITY));
    assign empty     = (r_count == '0);

    assign cmd.ins = accept && !is_remove && !full;
    assign cmd.rem = accept && is_remove && !empty;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic signed [VALUE_WIDTH-1:0] prev_value;
            logic                          prev_valid;
            logic                          prev_ge;
            logic signed [VALUE_WIDTH-1:0] next_value;
            logic                          next_valid;

            // The head cell sees an always-greater neighbor on its left; the
            // tail cell sees an empty neighbor on its right.
            if (gi == 0) begin : g_head
                assign prev_value = i_value;
                assign prev_valid = 1'b1;
                assign prev_ge    = 1'b1;
            end else begin : g_body
                assign prev_value = w_value[gi-1];
                assign prev_valid = w_valid[gi-1];
                assign prev_ge    = w_ge[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_tail
                assign next_value = '0;
                assign next_valid = 1'b0;
            end else begin : g_link
                assign next_value = w_value[gi+1];
                assign next_valid = w_valid[gi+1];
            end

            mpq_cell #(
                .VALUE_WIDTH(VALUE_WIDTH)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_cmd       (cmd),
                .i_new_value (i_value),
                .i_prev_value(prev_value),
                .i_prev_valid(prev_valid),
                .i_prev_ge   (prev_ge),
                .i_next_value(next_value),
                .i_next_valid(next_valid),
                .o_value     (w_value[gi]),
                .o_valid     (w_valid[gi]),
                .o_ge        (w_ge[gi])
            );
        end
    endgenerate

    always_comb begin
        n_count   = r_count;
        n_removed = '0;
        n_status  = mpq_pkg::ST_OK;
        if (is_remove) begin
            if (empty) begin
                n_status = mpq_pkg::ST_UNDERFLOW;
            end else begin
                n_removed = w_value[0];
                n_count   = CW'(r_count - 1'b1);
            end
        end else begin
            if (full) begin
                n_status = mpq_pkg::ST_OVERFLOW;
            end else begin
                n_count = CW'(r_count + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_removed <= n_removed;
            r_status  <= n_status;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_removed_value = r_removed;
    assign o_status        = r_status;
    assign o_count         = r_count;

endmodule

/* verif/max_priority_queue_sorted_tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// Sorted max-priority queue testbench
// Sends insert and remove requests through the input handshake, predicts each
// result with a sorted store of its own and compares it field by field with
// what the queue returns. A directed table comes first, then random phases
// that fill, drain and churn the queue while both sides idle at random.
// ============================================================================
module max_priority_queue_sorted_tb;

    localparam int CAPACITY    = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);
    localparam int RANDOM_REQUESTS = 1950;
    localparam int DRAIN_CYCLES = 8;
    localparam longint LIMIT_NS = 2_000_000;

    localparam logic signed [VALUE_WIDTH-1:0] MAX_VALUE = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_WIDTH-1:0] MIN_VALUE = 32'sh8000_0000;

    typedef struct {
        logic signed [VALUE_WIDTH-1:0] removed;
        mpq_pkg::t_status              status;
        logic [COUNT_WIDTH-1:0]        count;
    } t_queue_result;

    typedef struct {
        mpq_pkg::t_func                func;
        logic signed [VALUE_WIDTH-1:0] value;
        bit                            typed;
        t_queue_result                 want;
    } t_stim_row;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_valid;
    logic                             o_ready;
    logic                             i_func;
    logic signed [VALUE_WIDTH-1:0]    i_value;
    logic                             o_valid;
    logic                             i_ready;
    logic signed [VALUE_WIDTH-1:0]    o_removed_value;
    logic [mpq_pkg::STATUS_WIDTH-1:0] o_status;
    logic [COUNT_WIDTH-1:0]           o_count;

    // Sorted store that mirrors the queue, largest value first.
    logic signed [VALUE_WIDTH-1:0] sorted_store [CAPACITY];
    int                            held_count = 0;

    t_queue_result pending_results [$];
    t_stim_row     stim_rows [$];
    int            mismatches = 0;

    // Typed expectation of the request on the bus, updated with the payload.
    bit            row_typed;
    t_queue_result row_want;

    int burst_left = 0;
    int ready_left = 0;
    logic [7:0] ready_pat = 8'hFF;

    max_priority_queue_sorted #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_func          (i_func),
        .i_value         (i_value),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_removed_value (o_removed_value),
        .o_status        (o_status),
        .o_count         (o_count)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic t_queue_result queue_op_result(
        mpq_pkg::t_func func,
        logic signed [VALUE_WIDTH-1:0] value
    );
        t_queue_result r;
        int pos;
        int k;
        r.removed = '0;
        r.status  = mpq_pkg::ST_OK;
        if (func == mpq_pkg::FN_INSERT) begin
            if (held_count == CAPACITY) begin
                r.status = mpq_pkg::ST_OVERFLOW;
            end else begin
                // Equal values stay in arrival order: skip every entry >= value.
                pos = 0;
                while (pos < held_count && sorted_store[pos] >= value) pos++;
                for (k = held_count; k > pos; k--) sorted_store[k] = sorted_store[k-1];
                sorted_store[pos] = value;
                held_count++;
            end
        end else begin
            if (held_count == 0) begin
                r.status = mpq_pkg::ST_UNDERFLOW;
            end else begin
                r.removed = sorted_store[0];
                for (k = 0; k + 1 < held_count; k++) sorted_store[k] = sorted_store[k+1];
                held_count--;
            end
        end
        r.count = COUNT_WIDTH'(held_count);
        return r;
    endfunction

    function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return MAX_VALUE - $urandom_range(0, 2);
            1: return MIN_VALUE + $urandom_range(0, 2);
            2: return $signed($urandom_range(0, 8)) - 4;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_row(mpq_pkg::t_func func, logic signed [VALUE_WIDTH-1:0] value,
                           bit typed,
                           logic signed [VALUE_WIDTH-1:0] removed = '0,
                           mpq_pkg::t_status status = mpq_pkg::ST_OK, int count = 0);
        t_stim_row row;
        row.func         = func;
        row.value        = value;
        row.typed        = typed;
        row.want.removed = removed;
        row.want.status  = status;
        row.want.count   = COUNT_WIDTH'(count);
        stim_rows.push_back(row);
    endtask

    // Holds the request until accepted, then idles between bursts.
    task automatic send_request(t_stim_row row);
        int gap;
        i_valid   <= 1'b1;
        i_func    <= row.func;
        i_value   <= row.value;
        row_typed <= row.typed;
        row_want  <= row.want;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 24);
            gap = $urandom_range(1, 8);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end else begin
            burst_left--;
        end
    endtask

    // Receiver stalls on a rotating pattern that is reloaded now and then.
    always @(posedge i_clk) begin
        if (ready_left == 0) begin
            ready_left <= $urandom_range(16, 96);
            case ($urandom_range(0, 3))
                0: ready_pat <= 8'hFF;
                1: ready_pat <= 8'($urandom & $urandom & $urandom) | 8'h01;
                default: ready_pat <= 8'($urandom) | 8'h01;
            endcase
        end else begin
            ready_left <= ready_left - 1;
            ready_pat  <= {ready_pat[0], ready_pat[7:1]};
        end
        i_ready <= ready_pat[0];
    end

    always @(posedge i_clk) begin : scoreboard
        t_queue_result predicted;
        t_queue_result want;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                predicted = queue_op_result(mpq_pkg::t_func'(i_func), i_value);
                if (row_typed) begin
                    pending_results.push_back(row_want);
                end else begin
                    pending_results.push_back(predicted);
                end
            end
            if (o_valid && i_ready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result: removed_value %0d status %0d count %0d",
                           o_removed_value, o_status, o_count);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_removed_value !== want.removed) begin
                        $error("removed_value: expected %0d, actual %0d",
                               want.removed, o_removed_value);
                        mismatches++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, o_status);
                        mismatches++;
                    end
                    if (o_count !== want.count) begin
                        $error("count: expected %0d, actual %0d", want.count, o_count);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial begin
        t_stim_row row;
        int fill_bias;
        int phase_left;
        int sent;
        int k;

        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_func    <= mpq_pkg::FN_INSERT;
        i_value   <= '0;
        row_typed <= 1'b0;
        row_want  <= '{removed: '0, status: mpq_pkg::ST_OK, count: '0};

        // Directed part: underflow after reset, extremes, ties, a full queue.
        add_row(mpq_pkg::FN_REMOVE, 0, 1, 0, mpq_pkg::ST_UNDERFLOW, 0);
        add_row(mpq_pkg::FN_INSERT, MAX_VALUE, 1, 0, mpq_pkg::ST_OK, 1);
        add_row(mpq_pkg::FN_INSERT, MIN_VALUE, 1, 0, mpq_pkg::ST_OK, 2);
        add_row(mpq_pkg::FN_INSERT, 0, 0);
        add_row(mpq_pkg::FN_INSERT, -1, 0);
        add_row(mpq_pkg::FN_INSERT, 1, 0);
        add_row(mpq_pkg::FN_INSERT, 0, 0);
        add_row(mpq_pkg::FN_REMOVE, 0, 1, MAX_VALUE, mpq_pkg::ST_OK, 5);
        add_row(mpq_pkg::FN_REMOVE, -1, 0);
        for (k = 0; k < 12; k++) begin
            add_row(mpq_pkg::FN_INSERT,
                    (k % 3 == 0) ? MIN_VALUE : (k % 3 == 1) ? MAX_VALUE : 5, 0);
        end
        add_row(mpq_pkg::FN_INSERT, 32'sh1234_5678, 1, 0, mpq_pkg::ST_OVERFLOW, CAPACITY);
        add_row(mpq_pkg::FN_REMOVE, 0, 0);
        add_row(mpq_pkg::FN_INSERT, MIN_VALUE, 0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_rows[i]) send_request(stim_rows[i]);

        // Random phases lean toward filling, draining or churning the queue.
        sent = 0;
        phase_left = 0;
        fill_bias = 50;
        row.typed = 0;
        row.want = '{removed: '0, status: mpq_pkg::ST_OK, count: '0};
        while (sent < RANDOM_REQUESTS) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(20, 60);
                case ($urandom_range(0, 2))
                    0: fill_bias = 85;
                    1: fill_bias = 15;
                    default: fill_bias = 50;
                endcase
            end
            row.func  = ($urandom_range(0, 99) < fill_bias) ? mpq_pkg::FN_INSERT
                                                            : mpq_pkg::FN_REMOVE;
            row.value = (row.func == mpq_pkg::FN_INSERT) ? pick_value() : $urandom;
            send_request(row);
            phase_left--;
            sent++;
        end
        i_valid <= 1'b0;
        @(posedge i_clk);

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
